[sv/lsaf_pkg.sv]
// Package with the types, constants and solve programme of the least-squares affine fit.
package lsaf_pkg;

  localparam int unsigned IN_W      = 12;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned USED_W    = 6;
  localparam int unsigned N_STEPS   = 20;
  localparam int unsigned STEP_DET  = 11;
  localparam int unsigned N_DIVS    = 3;
  localparam int unsigned N_TERMS   = 5;
  localparam int unsigned MEM_DEPTH = 10;
  localparam int unsigned MEM_AW    = 4;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned DIV_W     = 2;
  localparam int unsigned TERM_W    = 3;

  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};

  typedef enum logic [4:0] {
    ST_IDLE, ST_ACC, ST_MFA, ST_MFB, ST_MLB, ST_MRUN, ST_MEND,
    ST_DFA, ST_DFB, ST_DABS, ST_DRUN, ST_DRND, ST_DINC, ST_DSAT,
    ST_FIN, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_ACC, OP_FA, OP_FB, OP_LB, OP_MRUN, OP_MEND,
    OP_DFA, OP_DFB, OP_DABS, OP_DRUN, OP_DRND, OP_DINC, OP_DSAT, OP_FIN
  } op_t;

  typedef enum logic [4:0] {
    OPD_N, OPD_SX, OPD_SY, OPD_ST,
    OPD_SXX_SUM, OPD_SXY_SUM, OPD_SYY_SUM, OPD_SXT_SUM, OPD_SYT_SUM,
    OPD_SXX, OPD_SXY, OPD_SYY, OPD_SXT, OPD_SYT,
    OPD_D, OPD_N1, OPD_N2, OPD_N0, OPD_ND
  } opnd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_SINGULAR = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    logic  sub;
    logic  clr;
    logic  store;
    opnd_t dest;
  } step_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
    logic [DIV_W-1:0]  div;
    logic [TERM_W-1:0] term;
    logic              singular;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic det_pos;
  } stat_t;

  function automatic step_t step_f(logic [STEP_W-1:0] i);
    step_t s;
    case (i)
      5'd0:    s = '{OPD_N,   OPD_SXX_SUM, 1'b0, 1'b1, 1'b0, OPD_SXX};
      5'd1:    s = '{OPD_SX,  OPD_SX,      1'b1, 1'b0, 1'b1, OPD_SXX};
      5'd2:    s = '{OPD_N,   OPD_SXY_SUM, 1'b0, 1'b1, 1'b0, OPD_SXY};
      5'd3:    s = '{OPD_SX,  OPD_SY,      1'b1, 1'b0, 1'b1, OPD_SXY};
      5'd4:    s = '{OPD_N,   OPD_SYY_SUM, 1'b0, 1'b1, 1'b0, OPD_SYY};
      5'd5:    s = '{OPD_SY,  OPD_SY,      1'b1, 1'b0, 1'b1, OPD_SYY};
      5'd6:    s = '{OPD_N,   OPD_SXT_SUM, 1'b0, 1'b1, 1'b0, OPD_SXT};
      5'd7:    s = '{OPD_SX,  OPD_ST,      1'b1, 1'b0, 1'b1, OPD_SXT};
      5'd8:    s = '{OPD_N,   OPD_SYT_SUM, 1'b0, 1'b1, 1'b0, OPD_SYT};
      5'd9:    s = '{OPD_SY,  OPD_ST,      1'b1, 1'b0, 1'b1, OPD_SYT};
      5'd10:   s = '{OPD_SXX, OPD_SYY,     1'b0, 1'b1, 1'b0, OPD_D};
      5'd11:   s = '{OPD_SXY, OPD_SXY,     1'b1, 1'b0, 1'b1, OPD_D};
      5'd12:   s = '{OPD_SXT, OPD_SYY,     1'b0, 1'b1, 1'b0, OPD_N1};
      5'd13:   s = '{OPD_SYT, OPD_SXY,     1'b1, 1'b0, 1'b1, OPD_N1};
      5'd14:   s = '{OPD_SYT, OPD_SXX,     1'b0, 1'b1, 1'b0, OPD_N2};
      5'd15:   s = '{OPD_SXT, OPD_SXY,     1'b1, 1'b0, 1'b1, OPD_N2};
      5'd16:   s = '{OPD_ST,  OPD_D,       1'b0, 1'b1, 1'b0, OPD_N0};
      5'd17:   s = '{OPD_N1,  OPD_SX,      1'b1, 1'b0, 1'b0, OPD_N0};
      5'd18:   s = '{OPD_N2,  OPD_SY,      1'b1, 1'b0, 1'b1, OPD_N0};
      5'd19:   s = '{OPD_N,   OPD_D,       1'b0, 1'b1, 1'b1, OPD_ND};
      default: s = '{OPD_N,   OPD_N,       1'b0, 1'b1, 1'b0, OPD_SXX};
    endcase
    return s;
  endfunction

  function automatic opnd_t div_num_f(logic [DIV_W-1:0] i);
    opnd_t o;
    case (i)
      2'd0:    o = OPD_N1;
      2'd1:    o = OPD_N2;
      default: o = OPD_N0;
    endcase
    return o;
  endfunction

  function automatic opnd_t div_den_f(logic [DIV_W-1:0] i);
    opnd_t o;
    case (i)
      2'd0, 2'd1: o = OPD_D;
      default:    o = OPD_ND;
    endcase
    return o;
  endfunction

  function automatic logic [MEM_AW-1:0] mem_addr_f(opnd_t o);
    logic [4:0] d;
    d = 5'(o - OPD_SXX);
    return (o >= OPD_SXX) ? d[MEM_AW-1:0] : '0;
  endfunction

endpackage

[sv/lsaf_if.sv]
// Handshake interfaces for the calibration point and coefficient channels.
interface lsaf_in_if;
  import lsaf_pkg::*;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] first_coord;
  logic [IN_W-1:0] second_coord;
  logic [IN_W-1:0] target_value;
  logic            last_point;

  modport source (output valid, first_coord, second_coord, target_value, last_point,
                  input ready);
  modport sink (input valid, first_coord, second_coord, target_value, last_point,
                output ready);
endinterface

interface lsaf_out_if;
  import lsaf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_first;
  logic signed [COEF_W-1:0] coef_second;
  logic signed [COEF_W-1:0] coef_offset;
  logic [1:0]               status;
  logic [USED_W-1:0]        points_used;

  modport source (output valid, coef_first, coef_second, coef_offset, status, points_used,
                  input ready);
  modport sink (input valid, coef_first, coef_second, coef_offset, status, points_used,
                output ready);
endinterface

[sv/lsaf_seq.sv]
// Sequencer for point accumulation, the solve programme and the three divisions.
module lsaf_seq
  import lsaf_pkg::*;
#(
  parameter int unsigned WW = 110
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_last,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctl_t  ctl
);

  localparam int unsigned BIT_W = $clog2(WW + 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              last_r, last_nxt;
  logic              sing_r, sing_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      div_r   <= '0;
      term_r  <= '0;
      bit_r   <= '0;
      last_r  <= 1'b0;
      sing_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      div_r   <= div_nxt;
      term_r  <= term_nxt;
      bit_r   <= bit_nxt;
      last_r  <= last_nxt;
      sing_r  <= sing_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    div_nxt   = div_r;
    term_nxt  = term_r;
    bit_nxt   = bit_r;
    last_nxt  = last_r;
    sing_nxt  = sing_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          term_nxt = '0;
          step_nxt = '0;
          sing_nxt = 1'b0;
          if (stat.full) begin
            state_nxt = in_last ? ST_MFA : ST_IDLE;
          end else begin
            state_nxt = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        if (term_r == TERM_W'(N_TERMS - 1)) begin
          state_nxt = last_r ? ST_MFA : ST_IDLE;
        end else begin
          term_nxt = term_r + 1'b1;
        end
      end
      ST_MFA: state_nxt = ST_MFB;
      ST_MFB: state_nxt = ST_MLB;
      ST_MLB: begin
        bit_nxt   = '0;
        state_nxt = ST_MRUN;
      end
      ST_MRUN: begin
        if (bit_r == BIT_W'(WW - 1)) begin
          state_nxt = ST_MEND;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      ST_MEND: begin
        if (step_r == STEP_W'(STEP_DET) && !stat.det_pos) begin
          sing_nxt  = 1'b1;
          state_nxt = ST_FIN;
        end else if (step_r == STEP_W'(N_STEPS - 1)) begin
          div_nxt   = '0;
          state_nxt = ST_DFA;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = ST_MFA;
        end
      end
      ST_DFA: state_nxt = ST_DFB;
      ST_DFB: state_nxt = ST_DABS;
      ST_DABS: begin
        bit_nxt   = '0;
        state_nxt = ST_DRUN;
      end
      ST_DRUN: begin
        if (bit_r == BIT_W'(WW - 1)) begin
          state_nxt = ST_DRND;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      ST_DRND: state_nxt = ST_DINC;
      ST_DINC: state_nxt = ST_DSAT;
      ST_DSAT: begin
        if (div_r == DIV_W'(N_DIVS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          div_nxt   = div_r + 1'b1;
          state_nxt = ST_DFA;
        end
      end
      ST_FIN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.step     = step_r;
    ctl.div      = div_r;
    ctl.term     = term_r;
    ctl.singular = sing_r;
    in_ready     = (state_r == ST_IDLE);
    out_valid    = (state_r == ST_OUT);
    case (state_r)
      ST_IDLE: ctl.op = in_valid ? OP_LOAD : OP_IDLE;
      ST_ACC:  ctl.op = OP_ACC;
      ST_MFA:  ctl.op = OP_FA;
      ST_MFB:  ctl.op = OP_FB;
      ST_MLB:  ctl.op = OP_LB;
      ST_MRUN: ctl.op = OP_MRUN;
      ST_MEND: ctl.op = OP_MEND;
      ST_DFA:  ctl.op = OP_DFA;
      ST_DFB:  ctl.op = OP_DFB;
      ST_DABS: ctl.op = OP_DABS;
      ST_DRUN: ctl.op = OP_DRUN;
      ST_DRND: ctl.op = OP_DRND;
      ST_DINC: ctl.op = OP_DINC;
      ST_DSAT: ctl.op = OP_DSAT;
      ST_FIN:  ctl.op = OP_FIN;
      default: ctl.op = OP_IDLE;
    endcase
  end

endmodule

[sv/lsaf_dp.sv]
// Datapath with the point sums, the intermediate store and the shared add-shift unit.
module lsaf_dp
  import lsaf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 32,
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned WW         = 110
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_t                     ctl,
  output stat_t                    stat,
  input  logic [IN_W-1:0]          pt_first,
  input  logic [IN_W-1:0]          pt_second,
  input  logic [IN_W-1:0]          pt_target,
  output logic signed [COEF_W-1:0] coef_first,
  output logic signed [COEF_W-1:0] coef_second,
  output logic signed [COEF_W-1:0] coef_offset,
  output logic [1:0]               status,
  output logic [USED_W-1:0]        points_used
);

  localparam int unsigned CWE   = (COORD_BITS < IN_W) ? COORD_BITS : IN_W;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned S1_W  = CWE + CNT_W;
  localparam int unsigned S2_W  = 2 * CWE + CNT_W;

  logic [CNT_W-1:0] cnt_r;
  logic [S1_W-1:0]  sx_r, sy_r, st_r;
  logic [S2_W-1:0]  sxx_r, sxy_r, syy_r, sxt_r, syt_r;
  logic             ovf_r;

  logic [CWE-1:0]   x_r, y_r, t_r;
  logic [WW-1:0]    mem [MEM_DEPTH];
  logic [WW-1:0]    rd_data_r;
  logic [WW-1:0]    mul_a_r, mul_b_r, acc_r, rem_r, quo_r, den_r;
  logic             neg_r, rnd_r;
  logic [COEF_W-1:0] c1_r, c2_r, c0_r;
  logic [1:0]        status_r;
  logic [USED_W-1:0] used_r;

  step_t             stp;
  opnd_t             rd_sel, opv_sel;
  logic [MEM_AW-1:0] rd_addr;
  logic [WW-1:0]     opv;
  logic [CWE-1:0]    mp_a, mp_b;
  logic [2*CWE-1:0]  prod;
  logic [WW-1:0]     add_x, add_y, add_res, shifted, abs_val;
  logic              add_sub, add_cy;
  logic [WW:0]       add_full;
  logic [COEF_W-1:0] q_lo, sat;
  logic              q_hi;

  assign stp = step_f(ctl.step);

  always_comb begin
    case (ctl.op)
      OP_FB:   rd_sel = stp.b;
      OP_DFA:  rd_sel = div_num_f(ctl.div);
      OP_DFB:  rd_sel = div_den_f(ctl.div);
      default: rd_sel = stp.a;
    endcase
  end
  assign rd_addr = mem_addr_f(rd_sel);
  assign opv_sel = (ctl.op == OP_LB) ? stp.b : stp.a;

  always_comb begin
    case (opv_sel)
      OPD_N:       opv = WW'(cnt_r);
      OPD_SX:      opv = WW'(sx_r);
      OPD_SY:      opv = WW'(sy_r);
      OPD_ST:      opv = WW'(st_r);
      OPD_SXX_SUM: opv = WW'(sxx_r);
      OPD_SXY_SUM: opv = WW'(sxy_r);
      OPD_SYY_SUM: opv = WW'(syy_r);
      OPD_SXT_SUM: opv = WW'(sxt_r);
      OPD_SYT_SUM: opv = WW'(syt_r);
      default:     opv = rd_data_r;
    endcase
  end

  always_comb begin
    case (ctl.term)
      3'd0:    begin mp_a = x_r; mp_b = x_r; end
      3'd1:    begin mp_a = x_r; mp_b = y_r; end
      3'd2:    begin mp_a = y_r; mp_b = y_r; end
      3'd3:    begin mp_a = x_r; mp_b = t_r; end
      default: begin mp_a = y_r; mp_b = t_r; end
    endcase
  end
  assign prod = mp_a * mp_b;

  assign shifted = {rem_r[WW-2:0], quo_r[WW-1]};

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (ctl.op)
      OP_MRUN: begin
        add_x   = acc_r;
        add_y   = mul_a_r;
        add_sub = stp.sub;
      end
      OP_DABS: begin
        add_y   = quo_r;
        add_sub = 1'b1;
      end
      OP_DRUN: begin
        add_x   = shifted;
        add_y   = den_r;
        add_sub = 1'b1;
      end
      OP_DRND: begin
        add_x   = {rem_r[WW-2:0], 1'b0};
        add_y   = den_r;
        add_sub = 1'b1;
      end
      OP_DINC: begin
        add_x = quo_r;
        add_y = WW'(rnd_r);
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end
  assign add_full = {1'b0, add_x} + {1'b0, add_y ^ {WW{add_sub}}} + (WW + 1)'(add_sub);
  assign add_res  = add_full[WW-1:0];
  assign add_cy   = add_full[WW];
  assign abs_val  = (neg_r ? add_res : quo_r) << FRAC_BITS;

  assign q_hi = |quo_r[WW-1:COEF_W];
  assign q_lo = quo_r[COEF_W-1:0];
  always_comb begin
    if (neg_r) begin
      sat = (q_hi || q_lo > COEF_MIN) ? COEF_MIN : COEF_W'(0) - q_lo;
    end else begin
      sat = (q_hi || q_lo[COEF_W-1]) ? COEF_MAX : q_lo;
    end
  end

  assign stat.full    = (cnt_r == CNT_W'(MAX_POINTS));
  assign stat.det_pos = !acc_r[WW-1] && (|acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      st_r  <= '0;
      sxx_r <= '0;
      sxy_r <= '0;
      syy_r <= '0;
      sxt_r <= '0;
      syt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      case (ctl.op)
        OP_LOAD: begin
          if (stat.full) begin
            ovf_r <= 1'b1;
          end
        end
        OP_ACC: begin
          case (ctl.term)
            3'd0: begin
              sxx_r <= sxx_r + S2_W'(prod);
              cnt_r <= cnt_r + 1'b1;
              sx_r  <= sx_r + S1_W'(x_r);
              sy_r  <= sy_r + S1_W'(y_r);
              st_r  <= st_r + S1_W'(t_r);
            end
            3'd1:    sxy_r <= sxy_r + S2_W'(prod);
            3'd2:    syy_r <= syy_r + S2_W'(prod);
            3'd3:    sxt_r <= sxt_r + S2_W'(prod);
            default: syt_r <= syt_r + S2_W'(prod);
          endcase
        end
        OP_FIN: begin
          cnt_r <= '0;
          sx_r  <= '0;
          sy_r  <= '0;
          st_r  <= '0;
          sxx_r <= '0;
          sxy_r <= '0;
          syy_r <= '0;
          sxt_r <= '0;
          syt_r <= '0;
          ovf_r <= 1'b0;
        end
        default: begin
          ovf_r <= ovf_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    case (ctl.op)
      OP_LOAD: begin
        x_r <= pt_first[CWE-1:0];
        y_r <= pt_second[CWE-1:0];
        t_r <= pt_target[CWE-1:0];
      end
      OP_FB: mul_a_r <= opv;
      OP_LB: begin
        mul_b_r <= opv;
        if (stp.clr) begin
          acc_r <= '0;
        end
      end
      OP_MRUN: begin
        if (mul_b_r[0]) begin
          acc_r <= add_res;
        end
        mul_a_r <= {mul_a_r[WW-2:0], 1'b0};
        mul_b_r <= {1'b0, mul_b_r[WW-1:1]};
      end
      OP_MEND: begin
        if (stp.store) begin
          mem[mem_addr_f(stp.dest)] <= acc_r;
        end
      end
      OP_DFB: begin
        quo_r <= rd_data_r;
        neg_r <= rd_data_r[WW-1];
      end
      OP_DABS: begin
        den_r <= rd_data_r;
        quo_r <= abs_val;
        rem_r <= '0;
      end
      OP_DRUN: begin
        quo_r <= {quo_r[WW-2:0], add_cy};
        rem_r <= add_cy ? add_res : shifted;
      end
      OP_DRND: rnd_r <= add_cy;
      OP_DINC: quo_r <= add_res;
      OP_DSAT: begin
        case (ctl.div)
          2'd0:    c1_r <= sat;
          2'd1:    c2_r <= sat;
          default: c0_r <= sat;
        endcase
      end
      OP_FIN: begin
        if (ctl.singular) begin
          c1_r <= '0;
          c2_r <= '0;
          c0_r <= '0;
        end
        if (ovf_r) begin
          status_r <= STAT_OVERFLOW;
        end else if (ctl.singular) begin
          status_r <= STAT_SINGULAR;
        end else begin
          status_r <= STAT_OK;
        end
        used_r <= USED_W'(cnt_r);
      end
      default: begin
        rnd_r <= rnd_r;
      end
    endcase
  end

  assign coef_first  = c1_r;
  assign coef_second = c2_r;
  assign coef_offset = c0_r;
  assign status      = status_r;
  assign points_used = used_r;

endmodule

[sv/least_squares_affine_fit.sv]
// Top level of the least-squares affine fit for touch calibration.
//
//   channel  direction  word
//   in_ch    sink       first_coord, second_coord, target_value, last_point
//   out_ch   source     coef_first, coef_second, coef_offset, status, points_used
//
// Each point is accepted and then its five products are added with a single small
// multiplier. The last point then runs the solve on one shared add-shift unit: 20
// bit-serial products and three divisions on WW-bit words,
// where WW = 5*min(COORD_BITS,12) + 5*clog2(MAX_POINTS+1) + FRAC_BITS + 4 (110 by default).
// Reset is synchronous and clears the sums and the sequencer.
// The input is not ready during the solve nor while a result word waits on out_ch.
module least_squares_affine_fit
  import lsaf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 32,
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  lsaf_in_if.sink    in_ch,
  lsaf_out_if.source out_ch
);

  localparam int unsigned CWE   = (COORD_BITS < IN_W) ? COORD_BITS : IN_W;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned WW    = 5 * CWE + 5 * CNT_W + FRAC_BITS + 4;

  ctl_t  ctl;
  stat_t stat;

  lsaf_seq #(
    .WW(WW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_point),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  lsaf_dp #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .WW        (WW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .pt_first   (in_ch.first_coord),
    .pt_second  (in_ch.second_coord),
    .pt_target  (in_ch.target_value),
    .coef_first (out_ch.coef_first),
    .coef_second(out_ch.coef_second),
    .coef_offset(out_ch.coef_offset),
    .status     (out_ch.status),
    .points_used(out_ch.points_used)
  );

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("Input ready while a result word is pending.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && !stat.full |=> !in_ch.ready)
    else $error("Input still ready after a point was accepted.");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == 2'(STAT_SINGULAR) |->
      out_ch.coef_first == '0 && out_ch.coef_second == '0 && out_ch.coef_offset == '0)
    else $error("Singular fit reported with non-zero coefficients.");

endmodule

[bench/least_squares_affine_fit_test.sv]
// Testbench for the least-squares affine fit: point sets in, predicted coefficients checked.
`timescale 1ns / 100ps

module least_squares_affine_fit_test;
  import lsaf_pkg::*;

  localparam int unsigned MAX_PTS    = 32;
  localparam int unsigned FRAC       = 16;
  localparam int unsigned STALL_MAX  = 50000;
  localparam int unsigned RAND_ITEMS = 1500;

  typedef logic [255:0] wide_t;

  typedef struct {
    logic [COEF_W-1:0] c_first;
    logic [COEF_W-1:0] c_second;
    logic [COEF_W-1:0] c_offset;
    status_t           status;
    logic [USED_W-1:0] used;
  } fit_t;

  class fit_scoreboard;
    int unsigned count;
    logic [63:0] s_xx, s_xy, s_yy, s_x, s_y, s_xt, s_yt, s_t;
    bit          dropped;
    fit_t        fits_due[$];
    int          errors;

    function new();
      clear_sums();
      errors = 0;
    endfunction

    function void clear_sums();
      count = 0;
      s_xx = 0; s_xy = 0; s_yy = 0; s_x = 0; s_y = 0;
      s_xt = 0; s_yt = 0; s_t = 0;
      dropped = 0;
    endfunction

    function logic [COEF_W-1:0] q_divide(wide_t num, wide_t den);
      logic  neg;
      wide_t m, q, r;
      neg = num[255];
      m = neg ? -num : num;
      m = m << FRAC;
      q = m / den;
      r = m % den;
      if ((r << 1) >= den) q = q + 1;
      if (q[255:32] != 0) return neg ? COEF_MIN : COEF_MAX;
      if (neg) return (q > 256'h8000_0000) ? COEF_MIN : -q[31:0];
      return (q > 256'h7FFF_FFFF) ? COEF_MAX : q[31:0];
    endfunction

    function void note_point(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                             logic [IN_W-1:0] t, logic last);
      wide_t n, sx, sy, st, dxx, dxy, dyy, dxt, dyt, d, n1, n2, n0;
      fit_t  f;
      if (count < MAX_PTS) begin
        count++;
        s_xx += x * x; s_xy += x * y; s_yy += y * y;
        s_x += x; s_y += y;
        s_xt += x * t; s_yt += y * t; s_t += t;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      n = count; sx = s_x; sy = s_y; st = s_t;
      dxx = n * wide_t'(s_xx) - sx * sx;
      dxy = n * wide_t'(s_xy) - sx * sy;
      dyy = n * wide_t'(s_yy) - sy * sy;
      dxt = n * wide_t'(s_xt) - sx * st;
      dyt = n * wide_t'(s_yt) - sy * st;
      d = dxx * dyy - dxy * dxy;
      f.c_first = 0; f.c_second = 0; f.c_offset = 0;
      if (d == 0 || d[255]) begin
        f.status = STAT_SINGULAR;
      end else begin
        f.status = STAT_OK;
        n1 = dxt * dyy - dyt * dxy;
        n2 = dyt * dxx - dxt * dxy;
        n0 = st * d - n1 * sx - n2 * sy;
        f.c_first = q_divide(n1, d);
        f.c_second = q_divide(n2, d);
        f.c_offset = q_divide(n0, n * d);
      end
      if (dropped) f.status = STAT_OVERFLOW;
      f.used = count[USED_W-1:0];
      fits_due.push_back(f);
      clear_sums();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    task check_fit(fit_t got);
      fit_t want;
      if (fits_due.size() == 0) begin
        report_mismatch("unexpected result word", got.used, 0);
        return;
      end
      want = fits_due.pop_front();
      if (got.c_first !== want.c_first)
        report_mismatch("coef_first", got.c_first, want.c_first);
      if (got.c_second !== want.c_second)
        report_mismatch("coef_second", got.c_second, want.c_second);
      if (got.c_offset !== want.c_offset)
        report_mismatch("coef_offset", got.c_offset, want.c_offset);
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.used !== want.used)
        report_mismatch("points_used", got.used, want.used);
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int unsigned stall_cycles;
  fit_scoreboard fits;

  lsaf_in_if  in_if ();
  lsaf_out_if out_if ();

  least_squares_affine_fit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 16);
  endfunction

  task automatic send_point(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                            logic [IN_W-1:0] t, logic last);
    while (idle_now()) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.first_coord  <= x;
    in_if.second_coord <= y;
    in_if.target_value <= t;
    in_if.last_point   <= last;
    do @(posedge clk); while (!in_if.ready);
    fits.note_point(x, y, t, last);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (fits.fits_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_set(output int unsigned len);
    int unsigned kind, lo, hi;
    kind = $urandom_range(99);
    if (kind < 5) len = $urandom_range(1, 2);
    else if (kind < 9) len = $urandom_range(30, 36);
    else len = $urandom_range(3, 8);
    lo = 0;
    hi = 4095;
    if ($urandom_range(3) == 0) begin
      lo = $urandom_range(4080);
      hi = lo + $urandom_range(15);
    end
    for (int unsigned i = 0; i < len; i++)
      send_point(IN_W'($urandom_range(hi, lo)), IN_W'($urandom_range(hi, lo)),
                 IN_W'($urandom_range(4095)), i == len - 1);
  endtask

  always @(posedge clk) begin
    out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    fit_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.c_first = out_if.coef_first;
      got.c_second = out_if.coef_second;
      got.c_offset = out_if.coef_offset;
      got.status = status_t'(out_if.status);
      got.used = out_if.points_used;
      fits.check_fit(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("FAIL least_squares_affine_fit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned sent, sets, len;
    fits = new();
    calm = 0;
    stall_cycles = 0;
    rst_n = 0;
    out_if.ready = 0;
    in_if.valid = 0;
    in_if.first_coord = 0;
    in_if.second_coord = 0;
    in_if.target_value = 0;
    in_if.last_point = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A single point gives a singular system.
    send_point(0, 0, 0, 1);
    // Three corners with full-scale target.
    send_point(0, 0, 4095, 0);
    send_point(4095, 0, 0, 0);
    send_point(0, 4095, 4095, 1);
    // Collinear points are singular.
    send_point(1, 1, 7, 0);
    send_point(2, 2, 9, 0);
    send_point(4095, 4095, 4095, 1);
    wait_drained();
    // Tightly clustered points force the offset to saturate.
    send_point(4094, 4095, 0, 0);
    send_point(4095, 4095, 4095, 0);
    send_point(4095, 4094, 0, 1);
    send_point(4095, 4095, 4095, 0);
    send_point(4094, 4095, 4095, 0);
    send_point(4095, 4094, 0, 1);
    // Exact identity mapping.
    send_point(100, 200, 100, 0);
    send_point(3000, 50, 3000, 0);
    send_point(700, 4000, 700, 0);
    send_point(4095, 4095, 4095, 1);
    wait_drained();

    sent = 0;
    sets = 0;
    while (sent < RAND_ITEMS) begin
      calm = (sets >= 60 && sets < 90);
      if (sets % 20 == 19) wait_drained();
      send_random_set(len);
      sent += len;
      sets++;
    end
    calm = 0;
    in_if.valid <= 1'b0;
    while (fits.fits_due.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (fits.errors == 0 && fits.fits_due.size() == 0) begin
      $display("PASS least_squares_affine_fit");
    end else begin
      $display("FAIL least_squares_affine_fit");
    end
    $finish;
  end

endmodule

[sim.f]
sv/lsaf_pkg.sv
sv/lsaf_if.sv
sv/lsaf_seq.sv
sv/lsaf_dp.sv
sv/least_squares_affine_fit.sv
bench/least_squares_affine_fit_test.sv
